@@ design/hpsc_pkg.sv @@
package hpsc_pkg;

   localparam int SLOT_COUNT   = 512;
   localparam int HINT_BUCKETS = 256;
   localparam int SLOT_BITS    = $clog2(SLOT_COUNT);
   localparam int HINT_BITS    = $clog2(HINT_BUCKETS);
   localparam int CNT_BITS     = SLOT_BITS + 1;
   localparam int SWEEP_COUNT  = (SLOT_COUNT > HINT_BUCKETS) ? SLOT_COUNT : HINT_BUCKETS;
   localparam int SWEEP_BITS   = $clog2(SWEEP_COUNT);
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);

   localparam logic [16:0] HASH_MUL     = 17'd65437;
   localparam int          HASH_SHIFT_A = 6;
   localparam int          HASH_SHIFT_B = 13;
   localparam logic [7:0]  AGE_WRAP     = 8'hFF;

   typedef enum logic [2:0] {
      OP_REMEMBER   = 3'd0,
      OP_FORGET     = 3'd1,
      OP_UPD_ALL    = 3'd2,
      OP_UPD_SEQ    = 3'd3,
      OP_UPD_AGE    = 3'd4,
      OP_FIND_INODE = 3'd5,
      OP_FIND_SEQ   = 3'd6,
      OP_CLEAR      = 3'd7
   } op_type;

   typedef struct packed {
      logic        valid;
      logic [7:0]  age;
      logic [31:0] tag;
      logic [31:0] seq;
      logic [22:0] pid;
      logic [63:0] inode;
   } entry_type;

   typedef struct packed {
      op_type                 op;
      logic [63:0]            inode;
      logic [31:0]            seq;
      logic [22:0]            pid;
      logic [31:0]            tag;
      logic [SLOT_BITS-1:0]   start;
      logic [HINT_BITS-1:0]   ibkt;
      logic [HINT_BITS-1:0]   sbkt;
   } work_type;

   // multiply-shift hash; only the low bucket bits of the product matter
   function automatic logic [HINT_BITS-1:0] bucket_of(input logic [63:0] v);
      logic [HINT_BITS-1:0] prod;
      prod = HINT_BITS'(v[HINT_BITS-1:0] * HASH_MUL);
      return prod + HINT_BITS'(v >> HASH_SHIFT_A) + HINT_BITS'(v >> HASH_SHIFT_B);
   endfunction

endpackage

@@ design/hpsc_req_if.sv @@
interface hpsc_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  cmd;
   logic [63:0] inode_key;
   logic [31:0] seq_value;
   logic [22:0] proc_id;
   logic [31:0] path_tag;
   logic [8:0]  start_slot;

   modport source (output valid, cmd, inode_key, seq_value, proc_id, path_tag, start_slot,
                   input ready);
   modport sink (input valid, cmd, inode_key, seq_value, proc_id, path_tag, start_slot,
                 output ready);
endinterface

@@ design/hpsc_rsp_if.sv @@
interface hpsc_rsp_if;
   logic        valid;
   logic        ready;
   logic        found;
   logic [63:0] hit_inode;
   logic [22:0] hit_proc_id;
   logic [31:0] hit_seq;
   logic [31:0] hit_path_tag;
   logic [8:0]  hit_slot;

   modport source (output valid, found, hit_inode, hit_proc_id, hit_seq, hit_path_tag,
                   hit_slot, input ready);
   modport sink (input valid, found, hit_inode, hit_proc_id, hit_seq, hit_path_tag,
                 hit_slot, output ready);
endinterface

@@ design/hpsc_front.sv @@
module hpsc_front
   import hpsc_pkg::*;
(
   hpsc_req_if.sink    req_ch,
   input  logic        q_full,
   output logic        q_push,
   output work_type    q_word
);

   assign req_ch.ready = !q_full;
   assign q_push       = req_ch.valid && !q_full;

   // classify the command and hash both keys up front
   always_comb begin
      q_word.op    = op_type'(req_ch.cmd);
      q_word.inode = req_ch.inode_key;
      q_word.seq   = req_ch.seq_value;
      q_word.pid   = req_ch.proc_id;
      q_word.tag   = req_ch.path_tag;
      q_word.start = SLOT_BITS'(req_ch.start_slot);
      q_word.ibkt  = bucket_of(req_ch.inode_key);
      q_word.sbkt  = bucket_of({32'd0, req_ch.seq_value});
   end

endmodule

@@ design/hpsc_queue.sv @@
module hpsc_queue
   import hpsc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  work_type push_word,
   output logic     full,
   input  logic     pop,
   output logic     not_empty,
   output work_type head
);

   work_type               q_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ff, wr_in;
   logic [QPTR_BITS-1:0]   rd_ff, rd_in;
   logic [QPTR_BITS:0]     cnt_ff, cnt_in;

   assign full      = (cnt_ff == (QPTR_BITS+1)'(QUEUE_DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign head      = q_ff[rd_ff];

   always_comb begin
      wr_in  = push ? QPTR_BITS'(wr_ff + 1'b1) : wr_ff;
      rd_in  = pop  ? QPTR_BITS'(rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff + (QPTR_BITS+1)'(push) - (QPTR_BITS+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

@@ design/hpsc_back.sv @@
module hpsc_back
   import hpsc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        wk_valid,
   input  work_type    wk,
   output logic        wk_pop,
   hpsc_rsp_if.source  rsp_ch
);

   typedef enum logic [2:0] {
      S_SWEEP,
      S_IDLE,
      S_HINT,
      S_PROBE,
      S_FINISH
   } state_type;

   entry_type              entry_mem [SLOT_COUNT];
   logic [SLOT_BITS-1:0]   ihint_mem [HINT_BUCKETS];
   logic [SLOT_BITS-1:0]   shint_mem [HINT_BUCKETS];

   state_type              state_ff;
   work_type               wk_ff;
   logic [7:0]             era_ff;
   logic [SWEEP_BITS-1:0]  sweep_ff;
   logic                   sweep_rsp_ff;
   logic [SLOT_BITS-1:0]   issue_slot_ff;
   logic [CNT_BITS-1:0]    issued_ff;
   logic [CNT_BITS-1:0]    checked_ff;
   logic                   pend_ff;
   logic [SLOT_BITS-1:0]   pend_slot_ff;
   logic [8:0]             oldest_dist_ff;
   logic [SLOT_BITS-1:0]   oldest_slot_ff;
   logic                   hit_ff;
   logic [SLOT_BITS-1:0]   slot_ff;
   entry_type              ent_ff;
   logic                   out_valid_ff;

   entry_type              ent_rd_ff;
   logic [SLOT_BITS-1:0]   ihint_rd_ff;
   logic [SLOT_BITS-1:0]   shint_rd_ff;

   logic [8:0]             age_gap;
   logic                   older;
   logic [8:0]             cur_dist;
   logic [SLOT_BITS-1:0]   cur_slot;
   logic                   match;
   logic [31:0]            seq_plus;
   logic [SLOT_BITS-1:0]   issue_next;

   logic                   fire;
   logic                   do_write;
   logic                   do_hints;
   entry_type              new_ent;
   entry_type              rep_ent;

   logic                   mem_we;
   logic [SLOT_BITS-1:0]   mem_waddr;
   entry_type              mem_wdata;
   logic                   hint_we;
   logic [HINT_BITS-1:0]   ih_waddr;
   logic [HINT_BITS-1:0]   sh_waddr;
   logic [SLOT_BITS-1:0]   hint_wdata;

   assign wk_pop = (state_ff == S_IDLE) && wk_valid;
   assign fire   = (state_ff == S_FINISH) && (!out_valid_ff || rsp_ch.ready);

   // probe evaluation of the slot whose read data just came back
   always_comb begin
      age_gap = (ent_rd_ff.age <= era_ff) ? ({1'b0, era_ff} - {1'b0, ent_rd_ff.age})
                                          : ({1'b0, AGE_WRAP} + {1'b0, era_ff}
                                             - {1'b0, ent_rd_ff.age});
      older    = oldest_dist_ff < age_gap;
      cur_dist = older ? age_gap : oldest_dist_ff;
      cur_slot = older ? pend_slot_ff : oldest_slot_ff;
      seq_plus = ent_rd_ff.seq + 32'd1;
      unique case (wk_ff.op)
         OP_REMEMBER: match = !ent_rd_ff.valid;
         OP_FIND_SEQ: match = ent_rd_ff.valid && (ent_rd_ff.seq != '0)
                              && ((ent_rd_ff.seq == wk_ff.seq) || (seq_plus == wk_ff.seq));
         OP_CLEAR:    match = 1'b0;
         default:     match = ent_rd_ff.valid && (ent_rd_ff.inode == wk_ff.inode);
      endcase
      issue_next = (issue_slot_ff == SLOT_BITS'(SLOT_COUNT - 1)) ? '0
                                                                 : issue_slot_ff + 1'b1;
   end

   // entry rewrite for the finishing command
   always_comb begin
      new_ent  = ent_ff;
      do_write = 1'b0;
      do_hints = 1'b0;
      unique case (wk_ff.op)
         OP_REMEMBER, OP_UPD_ALL: begin
            new_ent.valid = 1'b1;
            new_ent.age   = era_ff;
            new_ent.tag   = wk_ff.tag;
            new_ent.seq   = wk_ff.seq;
            new_ent.pid   = wk_ff.pid;
            new_ent.inode = wk_ff.inode;
            do_write      = hit_ff;
            do_hints      = hit_ff;
         end
         OP_FORGET: begin
            new_ent.valid = 1'b0;
            do_write      = hit_ff;
         end
         OP_UPD_SEQ: begin
            if (ent_ff.seq != wk_ff.seq) begin
               new_ent.seq = wk_ff.seq;
               new_ent.age = era_ff;
               do_write    = hit_ff;
            end
         end
         OP_UPD_AGE: begin
            new_ent.age = era_ff;
            do_write    = hit_ff;
         end
         OP_FIND_INODE, OP_FIND_SEQ, OP_CLEAR: begin
            do_write = 1'b0;
         end
      endcase
      rep_ent = (wk_ff.op == OP_FORGET) ? ent_ff : new_ent;
   end

   always_comb begin
      if (state_ff == S_SWEEP) begin
         mem_we     = (int'(sweep_ff) < SLOT_COUNT);
         mem_waddr  = SLOT_BITS'(sweep_ff);
         mem_wdata  = '0;
         hint_we    = (int'(sweep_ff) < HINT_BUCKETS);
         ih_waddr   = HINT_BITS'(sweep_ff);
         sh_waddr   = HINT_BITS'(sweep_ff);
         hint_wdata = '0;
      end else begin
         mem_we     = fire && do_write;
         mem_waddr  = slot_ff;
         mem_wdata  = new_ent;
         hint_we    = fire && do_hints;
         ih_waddr   = wk_ff.ibkt;
         sh_waddr   = wk_ff.sbkt;
         hint_wdata = slot_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[mem_waddr] <= mem_wdata;
      end
      ent_rd_ff <= entry_mem[issue_slot_ff];
   end

   always_ff @(posedge clock) begin
      if (hint_we) begin
         ihint_mem[ih_waddr] <= hint_wdata;
         shint_mem[sh_waddr] <= hint_wdata;
      end
      ihint_rd_ff <= ihint_mem[wk.ibkt];
      shint_rd_ff <= shint_mem[wk.sbkt];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_SWEEP;
         sweep_ff       <= '0;
         sweep_rsp_ff   <= 1'b0;
         era_ff         <= '0;
         out_valid_ff   <= 1'b0;
         pend_ff        <= 1'b0;
         hit_ff         <= 1'b0;
      end else begin
         // drop the word once taken, unless a new one replaces it this cycle
         if (out_valid_ff && rsp_ch.ready && !fire) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_SWEEP: begin
               era_ff <= '0;
               if (sweep_ff == SWEEP_BITS'(SWEEP_COUNT - 1)) begin
                  hit_ff   <= 1'b0;
                  state_ff <= sweep_rsp_ff ? S_FINISH : S_IDLE;
               end else begin
                  sweep_ff <= sweep_ff + 1'b1;
               end
            end
            S_IDLE: begin
               if (wk_valid) begin
                  wk_ff          <= wk;
                  issue_slot_ff  <= wk.start;
                  oldest_slot_ff <= wk.start;
                  oldest_dist_ff <= '0;
                  issued_ff      <= '0;
                  checked_ff     <= '0;
                  pend_ff        <= 1'b0;
                  if (wk.op == OP_CLEAR) begin
                     sweep_ff     <= '0;
                     sweep_rsp_ff <= 1'b1;
                     state_ff     <= S_SWEEP;
                  end else if (wk.op == OP_REMEMBER) begin
                     state_ff <= S_PROBE;
                  end else begin
                     state_ff <= S_HINT;
                  end
               end
            end
            S_HINT: begin
               // hint read issued in idle is back now
               issue_slot_ff <= (wk_ff.op == OP_FIND_SEQ) ? shint_rd_ff : ihint_rd_ff;
               state_ff      <= S_PROBE;
            end
            S_PROBE: begin
               if (issued_ff < CNT_BITS'(SLOT_COUNT)) begin
                  pend_ff       <= 1'b1;
                  pend_slot_ff  <= issue_slot_ff;
                  issue_slot_ff <= issue_next;
                  issued_ff     <= issued_ff + 1'b1;
               end else begin
                  pend_ff <= 1'b0;
               end
               if (pend_ff) begin
                  checked_ff     <= checked_ff + 1'b1;
                  oldest_dist_ff <= cur_dist;
                  oldest_slot_ff <= cur_slot;
                  if (match) begin
                     hit_ff   <= 1'b1;
                     slot_ff  <= pend_slot_ff;
                     ent_ff   <= ent_rd_ff;
                     state_ff <= S_FINISH;
                  end else if (checked_ff == CNT_BITS'(SLOT_COUNT - 1)) begin
                     // all slots checked with no match: remember evicts the oldest, other commands miss
                     hit_ff   <= (wk_ff.op == OP_REMEMBER);
                     slot_ff  <= cur_slot;
                     state_ff <= S_FINISH;
                  end
               end
            end
            S_FINISH: begin
               if (fire) begin
                  out_valid_ff        <= 1'b1;
                  rsp_ch.found        <= hit_ff;
                  rsp_ch.hit_inode    <= hit_ff ? rep_ent.inode : '0;
                  rsp_ch.hit_proc_id  <= hit_ff ? rep_ent.pid : '0;
                  rsp_ch.hit_seq      <= hit_ff ? rep_ent.seq : '0;
                  rsp_ch.hit_path_tag <= hit_ff ? rep_ent.tag : '0;
                  rsp_ch.hit_slot     <= hit_ff ? 9'(slot_ff) : '0;
                  if (wk_ff.op == OP_REMEMBER) begin
                     era_ff <= era_ff + 1'b1;
                  end
                  sweep_rsp_ff <= 1'b0;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_ch.valid = out_valid_ff;

endmodule

@@ design/hinted_probe_socket_cache.sv @@
//  channel   | dir | handshake     | word
//  req_ch    | in  | valid / ready | cmd, inode_key, seq_value, proc_id, path_tag, start_slot
//  rsp_ch    | out | valid / ready | found, hit_inode, hit_proc_id, hit_seq, hit_path_tag,
//            |     |               | hit_slot
//
//  Steps: the back end works a lookup or update through pick-up, hint read, probes of up to
//  SLOT_COUNT slots through the registered read port of the entry memory, and finish;
//  remember skips the hint read. Clear runs a sweep over max(SLOT_COUNT, HINT_BUCKETS)
//  entries, one entry a cycle.
//  Reset: synchronous; after reset the same sweep zeroes the memories before the first
//  word is worked on; the input queue still takes up to two words meanwhile.
//  Stalls: the output register holds a result until taken; the queue keeps the front open until it is full.
module hinted_probe_socket_cache
   import hpsc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   hpsc_req_if.sink   req_ch,
   hpsc_rsp_if.source rsp_ch
);

   logic     q_full;
   logic     q_push;
   logic     q_pop;
   logic     q_not_empty;
   work_type q_word;
   work_type q_head;

   // accept, classify and hash
   hpsc_front u_front (
      .req_ch (req_ch),
      .q_full (q_full),
      .q_push (q_push),
      .q_word (q_word)
   );

   // decouple the front from the probe engine
   hpsc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_word (q_word),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   // probe, write back, report
   hpsc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .wk_valid (q_not_empty),
      .wk       (q_head),
      .wk_pop   (q_pop),
      .rsp_ch   (rsp_ch)
   );

endmodule
